[hdl/gated_causal_depthwise_conv_assert.svh]
// Assertion macros for the gated causal depthwise convolution checker.
`ifndef GATED_CAUSAL_DEPTHWISE_CONV_ASSERT_SVH
`define GATED_CAUSAL_DEPTHWISE_CONV_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GCDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GCDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gcdc_pkg.sv]
// Shared constants, types and fixed-point helpers for the gated depthwise convolution.
package gcdc_pkg;

  localparam int CHANNELS    = 1024;
  localparam int TAPS        = 3;
  localparam int SLOTS       = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int FRAC     = 12;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = 16;
  localparam int HIST_LEN = TAPS - 1;
  localparam int SB       = SAMPLE_BITS;
  localparam int HROW_W   = HIST_LEN * SB;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int TAP_W    = $clog2(TAPS);
  localparam int HA_W     = SLOT_W + CH_W;
  localparam int HIST_DEPTH = 1 << HA_W;
  localparam int ACC_W    = SB + COEF_W + 4;
  localparam int MAC_W    = SB + COEF_W;
  localparam int GPROD_W  = COEF_W + SB;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_WEIGHT = 2'd1;
  localparam logic [1:0] ACT_BIAS   = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_BIAS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_STATE = 1'd1;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC - 1));
  localparam logic signed [ACC_W-1:0] SMP_MAX  = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMP_MIN  = -SMP_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -OUT_MAX - ACC_W'(1);

  typedef struct packed {
    logic signed [SB-1:0] val;
    logic                 clip;
  } smp_clip_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] val;
    logic                    clip;
  } out_clip_t;

  // round to nearest, ties upward, dropping FRAC fraction bits
  function automatic logic signed [ACC_W-1:0] rnd_q12(input logic signed [ACC_W-1:0] v);
    rnd_q12 = (v + RND_HALF) >>> FRAC;
  endfunction

  function automatic smp_clip_t clip_sample(input logic signed [ACC_W-1:0] v);
    smp_clip_t r;
    if (v > SMP_MAX) begin
      r.val  = SMP_MAX[SB-1:0];
      r.clip = 1'b1;
    end else if (v < SMP_MIN) begin
      r.val  = SMP_MIN[SB-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[SB-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic out_clip_t clip_out(input logic signed [ACC_W-1:0] v);
    out_clip_t r;
    if (v > OUT_MAX) begin
      r.val  = OUT_MAX[OUT_W-1:0];
      r.clip = 1'b1;
    end else if (v < OUT_MIN) begin
      r.val  = OUT_MIN[OUT_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[OUT_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/gated_causal_depthwise_conv.sv]
// Top level: gated causal depthwise convolution with history, weight and bias memories.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------------
//  in      | in_valid / in_ready       | action, read_slot, write_slot, channel, tap,
//          |                           | gate_in, gate_out, sample_value, coefficient
//  out     | out_valid / out_ready     | result, saturated
//  cfg     | cfg_we (no wait)          | cfg_index, cfg_data
//
// In a sample transaction one shared 16x16 MAC steps over the taps after a registered memory
// read. Weight and bias transactions leave in_ready high.
// After reset the history memory is cleared one row a cycle, all 16384 rows, with in_ready low.
// A finished result waits in the output register; a following sample stalls in its last
// step only while that register is still full.
module gated_causal_depthwise_conv (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [gcdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [0:0]                            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            action,
  input  logic [3:0]                            read_slot,
  input  logic [3:0]                            write_slot,
  input  logic [9:0]                            channel,
  input  logic [2:0]                            tap,
  input  logic signed [15:0]                    gate_in,
  input  logic signed [15:0]                    gate_out,
  input  logic signed [15:0]                    sample_value,
  input  logic signed [15:0]                    coefficient,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [15:0]                    result,
  output logic                                  saturated
);
  import gcdc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_CONV = 3'd3;
  localparam logic [2:0] ST_GATE = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic       use_bias;
  logic       keep_state;
  logic       clearing;
  logic [HA_W-1:0] clr_addr;

  logic [HROW_W-1:0]         hist_mem [HIST_DEPTH];
  logic [TAPS-1:0][COEF_W-1:0] weight_mem [CHANNELS];
  logic [COEF_W-1:0]         bias_mem [CHANNELS];

  logic [HROW_W-1:0]           hist_rdata;
  logic [TAPS-1:0][COEF_W-1:0] w_rdata;
  logic [COEF_W-1:0]           b_rdata;

  logic [CH_W-1:0]       ch_r;
  logic [SLOT_W-1:0]     wslot_r;
  logic signed [15:0]    c_r;
  logic signed [31:0]    prod_bv;
  logic signed [SB-1:0]  win [TAPS];
  logic signed [ACC_W-1:0] acc;
  logic signed [SB-1:0]  conv;
  logic signed [GPROD_W-1:0] gprod;
  logic [TAP_W-1:0]      k;
  logic                  sat;

  logic accept;
  logic chan_ok;
  logic sample_ok;
  logic hist_we;
  logic [HA_W-1:0]   hist_waddr;
  logic [HA_W-1:0]   hist_raddr;
  logic [HROW_W-1:0] hist_wdata;
  logic signed [MAC_W-1:0] mac_prod;
  logic signed [COEF_W-1:0] w_k;
  smp_clip_t x_c;
  smp_clip_t conv_c;
  out_clip_t res_c;
  logic out_free;

  assign in_ready  = (state == ST_IDLE) && !clearing;
  assign accept    = in_valid && in_ready;
  assign chan_ok   = int'(channel) < CHANNELS;
  assign sample_ok = (action == ACT_SAMPLE) && chan_ok &&
                     (int'(read_slot) < SLOTS) && (int'(write_slot) < SLOTS);
  assign out_free  = !out_valid || out_ready;

  assign hist_raddr = {read_slot[SLOT_W-1:0], channel[CH_W-1:0]};
  assign hist_we    = clearing || ((state == ST_CONV) && keep_state);
  assign hist_waddr = clearing ? clr_addr : {wslot_r, ch_r};

  always_comb begin
    hist_wdata = '0;
    if (!clearing) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_wdata[i*SB +: SB] = win[i+1];
      end
    end
  end

  assign w_k      = signed'(w_rdata[k]);
  assign mac_prod = MAC_W'(win[k]) * MAC_W'(w_k);
  assign x_c      = clip_sample(rnd_q12(ACC_W'(prod_bv)));
  assign conv_c   = clip_sample(rnd_q12(acc));
  assign res_c    = clip_out(rnd_q12(ACC_W'(gprod)));

  // memories
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (accept) begin
      hist_rdata <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (action == ACT_WEIGHT) && chan_ok && (int'(tap) < TAPS)) begin
      weight_mem[channel[CH_W-1:0]][tap[TAP_W-1:0]] <= coefficient;
    end
    if (accept) begin
      w_rdata <= weight_mem[channel[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (action == ACT_BIAS) && chan_ok) begin
      bias_mem[channel[CH_W-1:0]] <= coefficient;
    end
    if (accept) begin
      b_rdata <= bias_mem[channel[CH_W-1:0]];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      use_bias   <= 1'b0;
      keep_state <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USE_BIAS:   use_bias   <= cfg_data[0];
        REG_KEEP_STATE: keep_state <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // history clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + HA_W'(1);
      if (clr_addr == HA_W'(HIST_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // sequencer, control part
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && sample_ok) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          sat   <= x_c.clip;
          k     <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          k <= k + TAP_W'(1);
          if (k == TAP_W'(TAPS - 1)) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          sat   <= sat | conv_c.clip;
          state <= ST_GATE;
        end
        ST_GATE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sequencer, datapath part
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r    <= channel[CH_W-1:0];
      wslot_r <= write_slot[SLOT_W-1:0];
      c_r     <= gate_out;
      prod_bv <= 32'(gate_in) * 32'(sample_value);
    end
    case (state)
      ST_LOAD: begin
        for (int i = 0; i < HIST_LEN; i++) begin
          win[i] <= keep_state ? signed'(hist_rdata[i*SB +: SB]) : '0;
        end
        win[HIST_LEN] <= x_c.val;
        acc <= use_bias ? (ACC_W'(signed'(b_rdata)) <<< FRAC) : '0;
      end
      ST_MAC: begin
        acc <= acc + ACC_W'(mac_prod);
      end
      ST_CONV: begin
        conv <= conv_c.val;
      end
      ST_GATE: begin
        gprod <= GPROD_W'(c_r) * GPROD_W'(conv);
      end
      ST_DONE: begin
        if (out_free) begin
          result    <= res_c.val;
          saturated <= sat | res_c.clip;
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/gcdc_checker.sv]
// Port-level checker for the gated causal depthwise convolution, bound to the top level.
`include "gated_causal_depthwise_conv_assert.svh"

module gcdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         action,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] result,
  input logic               saturated
);
  import gcdc_pkg::*;

  `GCDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result) && $stable(saturated), "result transaction changed while stalled")
  `GCDC_ASSERT_NOW(a_clear_after_reset, $past(rst), !in_ready, "input taken during history clearing")
  `GCDC_ASSERT_NEXT(a_coef_no_result, in_valid && in_ready && (action != ACT_SAMPLE) && !out_valid, !out_valid, "coefficient transaction produced a result")
  `GCDC_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (action == ACT_SAMPLE), !in_ready, "input taken while a sample is in progress")

endmodule

bind gated_causal_depthwise_conv gcdc_checker u_gcdc_checker (.*);

[test/gated_causal_depthwise_conv_tb.sv]
`timescale 1ns / 1ps
// Testbench for the gated causal depthwise convolution: directed table, then random traffic.
module gated_causal_depthwise_conv_tb;
  import gcdc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 60000;
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int MAX_REPORTS     = 40;
  localparam int NUM_PHASES      = 6;

  typedef struct {
    logic [1:0]          action;
    logic [3:0]          read_slot;
    logic [3:0]          write_slot;
    logic [9:0]          channel;
    logic [2:0]          tap;
    logic signed [15:0]  gate_in;
    logic signed [15:0]  gate_out;
    logic signed [15:0]  sample_value;
    logic signed [15:0]  coefficient;
  } conv_req_t;

  typedef struct {
    logic signed [15:0] result;
    logic               saturated;
  } conv_res_t;

  typedef struct {
    conv_req_t req;
    bit        typed;
    conv_res_t want;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [0:0]            cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            action = '0;
  logic [3:0]            read_slot = '0;
  logic [3:0]            write_slot = '0;
  logic [9:0]            channel = '0;
  logic [2:0]            tap = '0;
  logic signed [15:0]    gate_in = '0;
  logic signed [15:0]    gate_out = '0;
  logic signed [15:0]    sample_value = '0;
  logic signed [15:0]    coefficient = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    result;
  logic                  saturated;

  gated_causal_depthwise_conv dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic signed [SB-1:0] hist_mem [SLOTS*CHANNELS][HIST_LEN];
  logic signed [15:0]   tap_w [CHANNELS][TAPS];
  logic signed [15:0]   ch_bias [CHANNELS];
  bit                   tap_known [CHANNELS][TAPS];
  bit                   bias_known [CHANNELS];
  bit                   in_pool [CHANNELS];
  int                   ready_ch[$];
  bit                   use_bias_q;
  bit                   keep_state_q;
  conv_res_t            pending_results[$];
  conv_res_t            oldest;

  int errors = 0;
  int watchdog = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  bit phase_ub [NUM_PHASES]   = '{0, 1, 1, 0, 1, 0};
  bit phase_ks [NUM_PHASES]   = '{1, 1, 0, 0, 1, 1};
  int phase_send [NUM_PHASES] = '{0, 66, 0, 14, 0, 14};
  int phase_recv [NUM_PHASES] = '{0, 0, 66, 14, 0, 14};

  function automatic longint round_q12(input longint v);
    return (v + 64'sd2048) >>> FRAC;
  endfunction

  function automatic longint clip_bits(input longint v, input int bits, inout bit flag);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // channel becomes usable for samples once every tap and its bias are loaded
  function automatic void note_coef(input int ch);
    bit full;
    full = bias_known[ch];
    for (int t = 0; t < TAPS; t++) full &= tap_known[ch][t];
    if (full && !in_pool[ch]) begin
      in_pool[ch] = 1'b1;
      ready_ch.push_back(ch);
    end
  endfunction

  function automatic bit conv_predict(input conv_req_t rq, output conv_res_t r);
    int     ch, rd_row, wr_row;
    longint x, acc, conv, res;
    longint win [TAPS];
    bit     sat;
    sat = 1'b0;
    r = '{default: '0};
    ch = int'(rq.channel);
    if (ch >= CHANNELS) return 1'b0;
    case (rq.action)
      ACT_WEIGHT: begin
        if (rq.tap < TAPS) begin
          tap_w[ch][rq.tap] = rq.coefficient;
          tap_known[ch][rq.tap] = 1'b1;
          note_coef(ch);
        end
        return 1'b0;
      end
      ACT_BIAS: begin
        ch_bias[ch] = rq.coefficient;
        bias_known[ch] = 1'b1;
        note_coef(ch);
        return 1'b0;
      end
      ACT_SAMPLE: ;
      default: return 1'b0;
    endcase
    if (rq.read_slot >= SLOTS || rq.write_slot >= SLOTS) return 1'b0;
    rd_row = int'(rq.read_slot) * CHANNELS + ch;
    wr_row = int'(rq.write_slot) * CHANNELS + ch;
    x = clip_bits(round_q12(longint'(rq.gate_in) * longint'(rq.sample_value)), SB, sat);
    for (int k = 0; k < HIST_LEN; k++)
      win[k] = keep_state_q ? longint'(hist_mem[rd_row][k]) : 64'sd0;
    win[HIST_LEN] = x;
    acc = 0;
    for (int k = 0; k < TAPS; k++) acc += win[k] * longint'(tap_w[ch][k]);
    if (use_bias_q) acc += longint'(ch_bias[ch]) * 64'sd4096;
    conv = clip_bits(round_q12(acc), SB, sat);
    res = clip_bits(round_q12(longint'(rq.gate_out) * conv), OUT_W, sat);
    if (keep_state_q)
      for (int k = 0; k < HIST_LEN; k++) hist_mem[wr_row][k] = win[k + 1][SB-1:0];
    r.result = res[15:0];
    r.saturated = sat;
    return 1'b1;
  endfunction

  function automatic table_row_t mk_row(input logic [1:0] act, input int rs, input int ws,
                                        input int ch, input int tp, input int b, input int c,
                                        input int v, input int coef, input bit typed,
                                        input int res, input bit sat);
    table_row_t row;
    row.req.action       = act;
    row.req.read_slot    = rs[3:0];
    row.req.write_slot   = ws[3:0];
    row.req.channel      = ch[9:0];
    row.req.tap          = tp[2:0];
    row.req.gate_in      = b[15:0];
    row.req.gate_out     = c[15:0];
    row.req.sample_value = v[15:0];
    row.req.coefficient  = coef[15:0];
    row.typed            = typed;
    row.want.result      = res[15:0];
    row.want.saturated   = sat;
    return row;
  endfunction

  function automatic logic signed [15:0] rand_q12(input int near_span);
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3, 4, 5, 6: return 16'(int'($urandom_range(0, 2 * near_span)) - near_span);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_channel();
    if ($urandom_range(0, 3) != 0)
      return ready_ch[$urandom_range(0, (ready_ch.size() < 4 ? ready_ch.size() : 4) - 1)];
    return ready_ch[$urandom_range(0, ready_ch.size() - 1)];
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  // both registers written one after the other, block must be idle
  task automatic apply_config(input bit ub, input bit ks);
    cfg_we <= 1'b1;
    cfg_index <= REG_USE_BIAS;
    cfg_data <= ub;
    @(posedge clk);
    use_bias_q = ub;
    cfg_index <= REG_KEEP_STATE;
    cfg_data <= ks;
    @(posedge clk);
    keep_state_q = ks;
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_req(input conv_req_t rq, input bit typed, input conv_res_t want);
    conv_res_t r;
    if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= rq.action;
    read_slot    <= rq.read_slot;
    write_slot   <= rq.write_slot;
    channel      <= rq.channel;
    tap          <= rq.tap;
    gate_in      <= rq.gate_in;
    gate_out     <= rq.gate_out;
    sample_value <= rq.sample_value;
    coefficient  <= rq.coefficient;
    do @(posedge clk); while (!in_ready);
    if (conv_predict(rq, r)) pending_results.push_back(typed ? want : r);
  endtask

  task automatic random_phase(input int n);
    conv_req_t rq;
    conv_res_t no_res;
    int        done, pick, ch;
    done = 0;
    no_res = '{default: '0};
    while (done < n) begin
      rq.action       = 2'($urandom);
      rq.read_slot    = 4'($urandom);
      rq.write_slot   = 4'($urandom);
      rq.channel      = 10'($urandom);
      rq.tap          = 3'($urandom);
      rq.gate_in      = rand_q12(8192);
      rq.gate_out     = rand_q12(8192);
      rq.sample_value = rand_q12(8192);
      rq.coefficient  = rand_q12(2048);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // full coefficient load for a randomly chosen channel
        ch = $urandom_range(0, CHANNELS - 1);
        rq.channel = ch[9:0];
        rq.action = ACT_WEIGHT;
        for (int t = 0; t < TAPS; t++) begin
          rq.tap = t[2:0];
          rq.coefficient = rand_q12(2048);
          send_req(rq, 1'b0, no_res);
        end
        rq.action = ACT_BIAS;
        rq.coefficient = rand_q12(2048);
        send_req(rq, 1'b0, no_res);
        done += TAPS + 1;
        continue;
      end else if (pick < 70) begin
        ch = pick_channel();
        rq.action = ACT_SAMPLE;
        rq.channel = ch[9:0];
        if ($urandom_range(0, 2) != 0) rq.read_slot = $urandom_range(0, 1) ? 4'd15 : 4'd0;
        if ($urandom_range(0, 1) != 0) rq.write_slot = rq.read_slot;
        done++;
      end else if (pick < 82) begin
        rq.action = ACT_WEIGHT;
        if ($urandom_range(0, 1) != 0) begin
          ch = pick_channel();
          rq.channel = ch[9:0];
        end
        if (rq.tap < TAPS) done++;
      end else if (pick < 94) begin
        rq.action = ACT_BIAS;
        if ($urandom_range(0, 1) != 0) begin
          ch = pick_channel();
          rq.channel = ch[9:0];
        end
        done++;
      end else begin
        rq.action = ACT_UNUSED;
      end
      send_req(rq, 1'b0, no_res);
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("result transaction with nothing outstanding");
      end else begin
        oldest = pending_results.pop_front();
        if (result !== oldest.result)
          report($sformatf("result %h, expected %h", result, oldest.result));
        if (saturated !== oldest.saturated)
          report($sformatf("saturated %b, expected %b", saturated, oldest.saturated));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog = 0;
    else watchdog++;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    table_row_t dir_rows[$];
    foreach (hist_mem[i, k]) hist_mem[i][k] = '0;
    use_bias_q = 1'b0;
    keep_state_q = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    apply_config(1'b0, 1'b1);

    // unit weights on channel 0, full-scale weights and most negative bias on the top channel
    for (int t = 0; t < TAPS; t++)
      dir_rows.push_back(mk_row(ACT_WEIGHT, 0, 0, 0, t, 0, 0, 0, 'h1000, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_BIAS, 0, 0, 0, 0, 0, 0, 0, 'h1000, 0, 0, 0));
    for (int t = 0; t < TAPS; t++)
      dir_rows.push_back(mk_row(ACT_WEIGHT, 0, 0, 1023, t, 0, 0, 0, 'h7FFF, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_BIAS, 0, 0, 1023, 0, 0, 0, 0, 'h8000, 0, 0, 0));
    // tap out of range and unused action: both dropped
    dir_rows.push_back(mk_row(ACT_WEIGHT, 0, 0, 0, 7, 0, 0, 0, 'h7FFF, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_UNUSED, 0, 0, 0, 0, 'h1000, 'h1000, 'h1000, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 0, 0, 'h1000, 'h1000, 'h1000, 0, 1, 'h1000, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 0, 0, 0, 0, 'h1000, 'h1000, 'h1000, 0, 1, 'h2000, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 15, 15, 1023, 0, 'h7FFF, 'h7FFF, 'h7FFF, 0,
                              1, 'h7FFF, 1));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 15, 15, 1023, 0, 'h8000, 'h8000, 'h8000, 0,
                              1, 'h8000, 1));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 1, 2, 0, 0, 'h1000, 0, 'h1000, 0, 1, 0, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 2, 2, 0, 0, 'h8000, 'h7FFF, 'h7FFF, 0, 0, 0, 0));
    // rounding ties at plus and minus one half
    dir_rows.push_back(mk_row(ACT_SAMPLE, 3, 3, 0, 0, 1, 'h1000, 'h0800, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 4, 4, 0, 0, 1, 'h1000, 'hF800, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 4, 3, 0, 0, 'hFFFF, 'hFFFF, 'h0800, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ACT_SAMPLE, 3, 4, 1023, 0, 0, 'h8000, 'h8000, 0, 0, 0, 0));

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_config(phase_ub[p], phase_ks[p]);
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == 4) hold_req = 1'b1;
      random_phase(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
